FILE: rtl/core/hsv2rgb_pkg.sv
// ----------------------------------------------------------------------------
// hsv2rgb_pkg
// Shared widths, constants and types for the HSV to RGB converter.
// ----------------------------------------------------------------------------
package hsv2rgb_pkg;

    // Field widths
    localparam int VALUE_WIDTH = 16;
    localparam int HUE_W       = 16;
    localparam int SAT_W       = 8;

    // Hue scaling: n = hue * 6, one sector spans 255.0 in Q8.8
    localparam int SECTORS  = 6;
    localparam int SEC_W    = 3;
    localparam int HUE_N_W  = HUE_W + 3;
    localparam int FRAC_W   = 16;
    localparam logic [HUE_N_W-1:0] HUE_SPAN = HUE_N_W'(65280);

    // Saturation full scale and rounding offset for p
    localparam logic [SAT_W-1:0] SAT_MAX = SAT_W'(255);
    localparam int PPROD_W = VALUE_WIDTH + SAT_W;
    localparam logic [PPROD_W-1:0] P_HALF = PPROD_W'(127);

    // Denominator for q and t: 255 * 65280, plus its half for rounding
    localparam int NUM_W  = 24;
    localparam logic [NUM_W-1:0] DEN      = NUM_W'(255 * 65280);
    localparam logic [NUM_W-1:0] DEN_HALF = NUM_W'((255 * 65280) / 2);
    localparam int PROD_W = VALUE_WIDTH + NUM_W;

    // Divide-by-255 unit: reciprocal estimate, then one correction
    localparam int DIV_IN_W = VALUE_WIDTH + 16;
    localparam int DIV_Q_W  = DIV_IN_W - 7;
    localparam logic [DIV_IN_W-1:0] DIV_RECIP =
        DIV_IN_W'((64'd1 << DIV_IN_W) / 64'd255);
    localparam logic [DIV_IN_W-1:0] DIV_BY = DIV_IN_W'(255);

    // Number of register stages from input to output
    localparam int STAGES = 8;

    typedef enum logic [SEC_W-1:0] {
        SEC_R_TO_Y = 3'd0,
        SEC_Y_TO_G = 3'd1,
        SEC_G_TO_C = 3'd2,
        SEC_C_TO_B = 3'd3,
        SEC_B_TO_M = 3'd4,
        SEC_M_TO_R = 3'd5
    } sector_t;

    typedef struct packed {
        logic ce1;
        logic ce2;
        logic ce3;
    } front_ce_t;

    typedef struct packed {
        logic est;
        logic corr;
    } div_ce_t;

    typedef struct packed {
        sector_t                sector;
        logic [VALUE_WIDTH-1:0] v;
    } side_t;

endpackage

FILE: rtl/core/hsv_to_rgb_converter.sv
// ----------------------------------------------------------------------------
// hsv_to_rgb_converter
// Pipelined HSV to RGB colour conversion, one colour word per clock while m_ready is high.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (s_valid / s_ready): s_hue is unsigned Q8.8 with the full
//   circle spanning 0.0 to 255.0, s_saturation is 0..255 (0 = grey),
//   s_brightness is the value channel. A hue of 255.0 or above wraps.
//   Result channel (m_valid / m_ready): m_red, m_green, m_blue on the same
//   scale as brightness, one result word per input word, in order.
//   Throughput: one word per cycle while m_ready is high; the 8-stage
//   pipeline is set by the chain sector split -> numerators -> v products
//   -> two divide-by-255 units (estimate + correct each) -> channel select.
//   Each stage carries a valid bit and advances when it is empty or the
//   stage after it advances, so bubbles are squeezed out while m_ready is
//   low and s_ready stays high until the pipeline is full.
//   Stall: words held by a low m_ready keep their values; nothing is lost
//   or repeated.
//   Reset (aresetn low, synchronous): all valid bits clear, s_ready rises
//   as soon as reset is released. No state is kept between words.
// ----------------------------------------------------------------------------
module hsv_to_rgb_converter (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic [hsv2rgb_pkg::HUE_W-1:0]       s_hue,
    input  logic [hsv2rgb_pkg::SAT_W-1:0]       s_saturation,
    input  logic [hsv2rgb_pkg::VALUE_WIDTH-1:0] s_brightness,
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic [hsv2rgb_pkg::VALUE_WIDTH-1:0] m_red,
    output logic [hsv2rgb_pkg::VALUE_WIDTH-1:0] m_green,
    output logic [hsv2rgb_pkg::VALUE_WIDTH-1:0] m_blue
);

    localparam int NS = hsv2rgb_pkg::STAGES;
    localparam int VW = hsv2rgb_pkg::VALUE_WIDTH;
    localparam int DW = hsv2rgb_pkg::DIV_IN_W;
    localparam int QW = hsv2rgb_pkg::DIV_Q_W;

    // Stage control: valid bit and clock enable per stage
    logic [NS:1] vld_reg;
    logic [NS:1] vld_next;
    logic [NS:1] ce;

    // Front end (stages 1-3)
    logic [DW-1:0]      y_p;
    logic [DW-1:0]      y_q;
    logic [DW-1:0]      y_t;
    hsv2rgb_pkg::side_t side3;

    // Side band: sector and v ride alongside the dividers
    hsv2rgb_pkg::side_t side4_reg;
    hsv2rgb_pkg::side_t side5_reg;
    hsv2rgb_pkg::side_t side6_reg;
    hsv2rgb_pkg::side_t side7_reg;

    // Divider results
    logic [QW-1:0] p5;
    logic [QW-1:0] zq5;
    logic [QW-1:0] zt5;
    logic [QW-1:0] q7;
    logic [QW-1:0] t7;
    logic [QW-1:0] p6_reg;
    logic [QW-1:0] p7_reg;

    // Stage 8 channel selection and output word
    logic [VW-1:0] v_s;
    logic [VW-1:0] p_s;
    logic [VW-1:0] q_s;
    logic [VW-1:0] t_s;
    logic [VW-1:0] red_next;
    logic [VW-1:0] green_next;
    logic [VW-1:0] blue_next;
    logic [VW-1:0] red_reg;
    logic [VW-1:0] green_reg;
    logic [VW-1:0] blue_reg;

    // A stage moves when it is empty or its successor moves
    always_comb begin
        ce[NS] = !vld_reg[NS] || m_ready;
        for (int k = NS - 1; k >= 1; k--) begin
            ce[k] = !vld_reg[k] || ce[k + 1];
        end
    end

    always_comb begin
        vld_next = vld_reg;
        if (ce[1]) begin
            vld_next[1] = s_valid;
        end
        for (int k = 2; k <= NS; k++) begin
            if (ce[k]) begin
                vld_next[k] = vld_reg[k - 1];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else begin
            vld_reg <= vld_next;
        end
    end

    // no word is taken while reset is held
    assign s_ready = ce[1] && aresetn;
    assign m_valid = vld_reg[NS];

    // Stages 1-3
    hsv2rgb_front u_front (
        .aclk (aclk),
        .ce   (hsv2rgb_pkg::front_ce_t'{ce1: ce[1], ce2: ce[2], ce3: ce[3]}),
        .hue  (s_hue),
        .sat  (s_saturation),
        .bri  (s_brightness),
        .y_p  (y_p),
        .y_q  (y_q),
        .y_t  (y_t),
        .side (side3)
    );

    // Stages 4-5: p is finished here, q and t get their first /255
    hsv2rgb_div255 u_div_p (
        .aclk     (aclk),
        .ce       (hsv2rgb_pkg::div_ce_t'{est: ce[4], corr: ce[5]}),
        .dividend (y_p),
        .quotient (p5)
    );

    hsv2rgb_div255 u_div_q1 (
        .aclk     (aclk),
        .ce       (hsv2rgb_pkg::div_ce_t'{est: ce[4], corr: ce[5]}),
        .dividend (y_q),
        .quotient (zq5)
    );

    hsv2rgb_div255 u_div_t1 (
        .aclk     (aclk),
        .ce       (hsv2rgb_pkg::div_ce_t'{est: ce[4], corr: ce[5]}),
        .dividend (y_t),
        .quotient (zt5)
    );

    // Stages 6-7: second /255 for q and t
    hsv2rgb_div255 u_div_q2 (
        .aclk     (aclk),
        .ce       (hsv2rgb_pkg::div_ce_t'{est: ce[6], corr: ce[7]}),
        .dividend (DW'(zq5)),
        .quotient (q7)
    );

    hsv2rgb_div255 u_div_t2 (
        .aclk     (aclk),
        .ce       (hsv2rgb_pkg::div_ce_t'{est: ce[6], corr: ce[7]}),
        .dividend (DW'(zt5)),
        .quotient (t7)
    );

    always_ff @(posedge aclk) begin
        if (ce[4]) begin
            side4_reg <= side3;
        end
        if (ce[5]) begin
            side5_reg <= side4_reg;
        end
        if (ce[6]) begin
            side6_reg <= side5_reg;
            p6_reg    <= p5;
        end
        if (ce[7]) begin
            side7_reg <= side6_reg;
            p7_reg    <= p6_reg;
        end
    end

    // None of p, q, t exceeds v, so the upper bits are zero
    assign v_s = side7_reg.v;
    assign p_s = VW'(p7_reg);
    assign q_s = VW'(q7);
    assign t_s = VW'(t7);

    // Six-sector placement; zero saturation gives p = q = t = v, i.e. grey
    always_comb begin
        case (side7_reg.sector)
            hsv2rgb_pkg::SEC_R_TO_Y: begin
                red_next = v_s; green_next = t_s; blue_next = p_s;
            end
            hsv2rgb_pkg::SEC_Y_TO_G: begin
                red_next = q_s; green_next = v_s; blue_next = p_s;
            end
            hsv2rgb_pkg::SEC_G_TO_C: begin
                red_next = p_s; green_next = v_s; blue_next = t_s;
            end
            hsv2rgb_pkg::SEC_C_TO_B: begin
                red_next = p_s; green_next = q_s; blue_next = v_s;
            end
            hsv2rgb_pkg::SEC_B_TO_M: begin
                red_next = t_s; green_next = p_s; blue_next = v_s;
            end
            default: begin
                red_next = v_s; green_next = p_s; blue_next = q_s;
            end
        endcase
    end

    // Stage 8: output register
    always_ff @(posedge aclk) begin
        if (ce[NS]) begin
            red_reg   <= red_next;
            green_reg <= green_next;
            blue_reg  <= blue_next;
        end
    end

    assign m_red   = red_reg;
    assign m_green = green_reg;
    assign m_blue  = blue_reg;

endmodule

FILE: rtl/core/hsv2rgb_div255.sv
// ----------------------------------------------------------------------------
// hsv2rgb_div255
// Two-stage floor division by 255: reciprocal multiply, then one correction.
// ----------------------------------------------------------------------------
module hsv2rgb_div255 (
    input  logic                                  aclk,
    input  hsv2rgb_pkg::div_ce_t                  ce,
    input  logic [hsv2rgb_pkg::DIV_IN_W-1:0]      dividend,
    output logic [hsv2rgb_pkg::DIV_Q_W-1:0]       quotient
);

    localparam int W  = hsv2rgb_pkg::DIV_IN_W;
    localparam int QW = hsv2rgb_pkg::DIV_Q_W;
    localparam int PW = 2 * W;

    logic [PW-1:0] prod;
    logic [QW-1:0] est_reg;
    logic [W-1:0]  y_reg;
    logic [W-1:0]  back;
    logic [W-1:0]  rem;
    logic          bump;
    logic [QW-1:0] quot_reg;

    // estimate is low by at most one
    assign prod = PW'(dividend) * PW'(hsv2rgb_pkg::DIV_RECIP);

    always_ff @(posedge aclk) begin
        if (ce.est) begin
            est_reg <= QW'(prod[PW-1:W]);
            y_reg   <= dividend;
        end
    end

    assign back = W'(est_reg) * hsv2rgb_pkg::DIV_BY;
    assign rem  = y_reg - back;
    assign bump = (rem >= hsv2rgb_pkg::DIV_BY);

    always_ff @(posedge aclk) begin
        if (ce.corr) begin
            quot_reg <= est_reg + QW'(bump);
        end
    end

    assign quotient = quot_reg;

endmodule

FILE: rtl/core/hsv2rgb_front.sv
// ----------------------------------------------------------------------------
// hsv2rgb_front
// Stages 1-3: sector and fraction, numerators, products with rounding bias.
// ----------------------------------------------------------------------------
module hsv2rgb_front (
    input  logic                                     aclk,
    input  hsv2rgb_pkg::front_ce_t                   ce,
    input  logic [hsv2rgb_pkg::HUE_W-1:0]            hue,
    input  logic [hsv2rgb_pkg::SAT_W-1:0]            sat,
    input  logic [hsv2rgb_pkg::VALUE_WIDTH-1:0]      bri,
    output logic [hsv2rgb_pkg::DIV_IN_W-1:0]         y_p,
    output logic [hsv2rgb_pkg::DIV_IN_W-1:0]         y_q,
    output logic [hsv2rgb_pkg::DIV_IN_W-1:0]         y_t,
    output hsv2rgb_pkg::side_t                       side
);

    localparam int NW  = hsv2rgb_pkg::HUE_N_W;
    localparam int FW  = hsv2rgb_pkg::FRAC_W;
    localparam int SW  = hsv2rgb_pkg::SAT_W;
    localparam int VW  = hsv2rgb_pkg::VALUE_WIDTH;
    localparam int UW  = hsv2rgb_pkg::NUM_W;
    localparam int XW  = hsv2rgb_pkg::PROD_W;
    localparam int PXW = hsv2rgb_pkg::PPROD_W;
    localparam int DW  = hsv2rgb_pkg::DIV_IN_W;
    localparam int CW  = hsv2rgb_pkg::SEC_W;

    // stage 1
    logic [NW-1:0]        n;
    logic [CW-1:0]        sec_raw;
    logic [NW-1:0]        rem_full;
    hsv2rgb_pkg::sector_t sector;

    hsv2rgb_pkg::sector_t s1_sector_reg;
    logic [FW-1:0]        s1_rem_reg;
    logic [SW-1:0]        s1_sat_reg;
    logic [VW-1:0]        s1_v_reg;

    // stage 2
    logic [UW-1:0]        sr;
    logic [UW-1:0]        st;
    hsv2rgb_pkg::sector_t s2_sector_reg;
    logic [UW-1:0]        s2_num_q_reg;
    logic [UW-1:0]        s2_num_t_reg;
    logic [SW-1:0]        s2_num_p_reg;
    logic [VW-1:0]        s2_v_reg;

    // stage 3
    hsv2rgb_pkg::sector_t s3_sector_reg;
    logic [XW-1:0]        s3_xq_reg;
    logic [XW-1:0]        s3_xt_reg;
    logic [PXW-1:0]       s3_xp_reg;
    logic [VW-1:0]        s3_v_reg;

    assign n = NW'(hue) * NW'(hsv2rgb_pkg::SECTORS);

    // sector = n / 65280 by threshold compare; a full circle wraps to 0
    always_comb begin
        sec_raw = '0;
        for (int k = 1; k <= hsv2rgb_pkg::SECTORS; k++) begin
            if (n >= NW'(k) * hsv2rgb_pkg::HUE_SPAN) begin
                sec_raw = CW'(k);
            end
        end
    end

    assign rem_full = n - NW'(sec_raw) * hsv2rgb_pkg::HUE_SPAN;
    assign sector   = (sec_raw == CW'(hsv2rgb_pkg::SECTORS)) ?
                      hsv2rgb_pkg::SEC_R_TO_Y : hsv2rgb_pkg::sector_t'(sec_raw);

    always_ff @(posedge aclk) begin
        if (ce.ce1) begin
            s1_sector_reg <= sector;
            s1_rem_reg    <= FW'(rem_full);
            s1_sat_reg    <= sat;
            s1_v_reg      <= bri;
        end
    end

    assign sr = UW'(s1_sat_reg) * UW'(s1_rem_reg);
    assign st = UW'(s1_sat_reg) * (UW'(hsv2rgb_pkg::HUE_SPAN) - UW'(s1_rem_reg));

    always_ff @(posedge aclk) begin
        if (ce.ce2) begin
            s2_sector_reg <= s1_sector_reg;
            s2_num_q_reg  <= hsv2rgb_pkg::DEN - sr;
            s2_num_t_reg  <= hsv2rgb_pkg::DEN - st;
            s2_num_p_reg  <= hsv2rgb_pkg::SAT_MAX - s1_sat_reg;
            s2_v_reg      <= s1_v_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (ce.ce3) begin
            s3_sector_reg <= s2_sector_reg;
            s3_xq_reg     <= XW'(s2_v_reg) * XW'(s2_num_q_reg)
                             + XW'(hsv2rgb_pkg::DEN_HALF);
            s3_xt_reg     <= XW'(s2_v_reg) * XW'(s2_num_t_reg)
                             + XW'(hsv2rgb_pkg::DEN_HALF);
            s3_xp_reg     <= PXW'(s2_v_reg) * PXW'(s2_num_p_reg) + hsv2rgb_pkg::P_HALF;
            s3_v_reg      <= s2_v_reg;
        end
    end

    // q and t divide by 256 * 65025: drop 8 bits here, two /255 steps follow
    assign y_q = s3_xq_reg[XW-1:8];
    assign y_t = s3_xt_reg[XW-1:8];
    assign y_p = DW'(s3_xp_reg);

    assign side.sector = s3_sector_reg;
    assign side.v      = s3_v_reg;

endmodule

FILE: rtl/core/hsv2rgb_checker.sv
// ----------------------------------------------------------------------------
// hsv2rgb_checker
// Port-level checks for the HSV to RGB converter, bound to the top level.
// ----------------------------------------------------------------------------
module hsv2rgb_checker (
    input logic                                aclk,
    input logic                                aresetn,
    input logic                                s_valid,
    input logic                                s_ready,
    input logic [hsv2rgb_pkg::HUE_W-1:0]       s_hue,
    input logic [hsv2rgb_pkg::SAT_W-1:0]       s_saturation,
    input logic [hsv2rgb_pkg::VALUE_WIDTH-1:0] s_brightness,
    input logic                                m_valid,
    input logic                                m_ready,
    input logic [hsv2rgb_pkg::VALUE_WIDTH-1:0] m_red,
    input logic [hsv2rgb_pkg::VALUE_WIDTH-1:0] m_green,
    input logic [hsv2rgb_pkg::VALUE_WIDTH-1:0] m_blue
);

    localparam int NS = hsv2rgb_pkg::STAGES;
    localparam int RW = 4;

    // consecutive cycles out of reset with m_ready high, saturating
    logic [RW-1:0] run_reg;
    logic [RW-1:0] run_next;

    always_comb begin
        if (!m_ready) begin
            run_next = '0;
        end else if (run_reg >= RW'(NS)) begin
            run_next = run_reg;
        end else begin
            run_next = run_reg + RW'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            run_reg <= '0;
        end else begin
            run_reg <= run_next;
        end
    end

    // empty or draining output stage never blocks the input
    a_ready_when_free: assert property (@(posedge aclk) disable iff (!aresetn)
        (!m_valid || m_ready) |-> s_ready)
        else $error("s_ready low while output stage is free");

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> (m_valid && $stable(m_red) && $stable(m_green)
                                   && $stable(m_blue)))
        else $error("result word changed while stalled");

    // free-running pipeline: grey input appears after full latency
    a_grey: assert property (@(posedge aclk) disable iff (!aresetn)
        (run_reg >= RW'(NS)
         && $past(s_valid && s_ready && s_saturation == 8'd0, NS))
        |-> (m_valid && m_red == $past(s_brightness, NS)
             && m_green == m_red && m_blue == m_red))
        else $error("zero saturation did not give grey");

    a_pure_red: assert property (@(posedge aclk) disable iff (!aresetn)
        (run_reg >= RW'(NS)
         && $past(s_valid && s_ready && s_hue == 16'd0 && s_saturation == 8'hFF, NS))
        |-> (m_valid && m_red == $past(s_brightness, NS)
             && m_green == '0 && m_blue == '0))
        else $error("hue zero at full saturation did not give pure red");

endmodule

bind hsv_to_rgb_converter hsv2rgb_checker u_hsv2rgb_checker (
    .aclk         (aclk),
    .aresetn      (aresetn),
    .s_valid      (s_valid),
    .s_ready      (s_ready),
    .s_hue        (s_hue),
    .s_saturation (s_saturation),
    .s_brightness (s_brightness),
    .m_valid      (m_valid),
    .m_ready      (m_ready),
    .m_red        (m_red),
    .m_green      (m_green),
    .m_blue       (m_blue)
);
